>>> sv/cab_pkg.sv
// shared constants, types and helpers for the clipped alpha blend blit
// no dependencies; compiled first

package cab_pkg;

	localparam int MAX_DIM_DEF = 2048;

	localparam int CFG_W   = 12;
	localparam int COORD_W = 11;
	localparam int PIX_W   = 32;
	localparam int ADDR_W  = 22;
	localparam int CHAN_W  = 8;
	localparam int NUM_CH  = 3;
	localparam int TGT_W   = 13;

	localparam int WIDTH_RST  = 960;
	localparam int HEIGHT_RST = 540;

	localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;
	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'hFF;

	typedef enum logic [1:0] {
		REG_PLACE_X     = 2'd0,
		REG_PLACE_Y     = 2'd1,
		REG_DEST_WIDTH  = 2'd2,
		REG_DEST_HEIGHT = 2'd3
	} cfg_reg_t;

	// load enables of the three pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} cab_adv_t;

	// floor(x / 255) for x up to 255 * 255
	function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
		logic [2*CHAN_W:0] sum;
		sum = {1'b0, x} + {9'd0, x[2*CHAN_W-1:CHAN_W]} + 17'd1;
		return sum[2*CHAN_W-1:CHAN_W];
	endfunction

endpackage

>>> sv/cab_if.sv
// stream interfaces for the blit pixel input and the write result
// depends on cab_pkg

interface cab_in_if
	import cab_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] src_col;
	logic [COORD_W-1:0] src_row;
	logic [PIX_W-1:0]   src_pixel;
	logic [PIX_W-1:0]   dst_pixel;

	modport source (output valid, src_col, src_row, src_pixel, dst_pixel, input ready);
	modport sink   (input valid, src_col, src_row, src_pixel, dst_pixel, output ready);
endinterface

interface cab_out_if
	import cab_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] dest_address;
	logic [PIX_W-1:0]  pixel_out;
	logic              write_enable;

	modport source (output valid, dest_address, pixel_out, write_enable, input ready);
	modport sink   (input valid, dest_address, pixel_out, write_enable, output ready);
endinterface

>>> sv/cab_blend.sv
// per-channel blend datapath: multiply in stage 2, divide by 255 and saturate after it
// depends on cab_pkg

module cab_blend
	import cab_pkg::*;
(
	input  logic                     clk,
	input  cab_adv_t                 adv,
	input  logic [NUM_CH*CHAN_W-1:0] src_rgb_s1,
	input  logic [NUM_CH*CHAN_W-1:0] dst_rgb_s1,
	input  logic [CHAN_W-1:0]        inv_s1,
	output logic [NUM_CH*CHAN_W-1:0] blend_rgb
);

	logic [2*CHAN_W-1:0] prod_s2 [NUM_CH];
	logic [CHAN_W-1:0]   src_s2  [NUM_CH];

	for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
		logic [CHAN_W:0] sum;

		always_ff @(posedge clk) begin
			if (adv.s2) begin
				prod_s2[c] <= dst_rgb_s1[c*CHAN_W +: CHAN_W] * inv_s1;
				src_s2[c]  <= src_rgb_s1[c*CHAN_W +: CHAN_W];
			end
		end

		assign sum = {1'b0, src_s2[c]} + {1'b0, div255(prod_s2[c])};
		assign blend_rgb[c*CHAN_W +: CHAN_W] = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
	end

endmodule

>>> sv/clipped_alpha_blend_blit_top.sv
// top level of the clipped alpha blend blit: config registers, clip and address pipeline
// depends on cab_pkg, cab_if (cab_in_if, cab_out_if) and cab_blend
//
//   port       dir   handshake       carries
//   pix        sink  valid / ready   src_col, src_row, src_pixel, dst_pixel
//   wb         src   valid / ready   dest_address, pixel_out, write_enable
//   cfg_*      in    cfg_wen only    cfg_index, cfg_data (no read-back)
//
// three register stages, one item per clock while wb is not stalled
// stage 1 holds the offset target, stage 2 the row offset, clip flag and channel products,
// stage 3 is the output register with the final address, pixel and write flag
// a stage loads whenever it is empty or the one after it moves, so bubbles close up
// and pix.ready stays high while wb is stalled until the pipeline is full
// arst_n clears the valid bits and sets the config registers to their reset values

module clipped_alpha_blend_blit_top
	import cab_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	cab_in_if.sink           pix,
	cab_out_if.source        wb
);

	// clamped dimension width and the widths that follow from it
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int CMP_W  = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int PROD_W = CFG_W + DIM_W;
	localparam int SUM_W  = PROD_W + 1;

	// dimensions are stored already clamped to MAX_DIM
	localparam logic [DIM_W-1:0] WIDTH_RST_C =
		(WIDTH_RST > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(WIDTH_RST);
	localparam logic [DIM_W-1:0] HEIGHT_RST_C =
		(HEIGHT_RST > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(HEIGHT_RST);

	// configuration registers
	logic [CFG_W-1:0] place_x_q;
	logic [CFG_W-1:0] place_y_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] cfg_dim;
	cfg_reg_t         cfg_sel;

	assign cfg_sel = cfg_reg_t'(cfg_index);
	assign cfg_dim = (32'(cfg_data) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_x_q <= '0;
			place_y_q <= '0;
			width_q   <= WIDTH_RST_C;
			height_q  <= HEIGHT_RST_C;
		end else if (cfg_wen) begin
			unique case (cfg_sel)
				REG_PLACE_X:     place_x_q <= cfg_data;
				REG_PLACE_Y:     place_y_q <= cfg_data;
				REG_DEST_WIDTH:  width_q   <= cfg_dim;
				REG_DEST_HEIGHT: height_q  <= cfg_dim;
				default:         place_x_q <= place_x_q;
			endcase
		end
	end

	// stage advance control: each stage loads when empty or when its successor moves
	logic     vld_s1, vld_s2, vld_s3;
	cab_adv_t adv;

	assign adv.s3    = !vld_s3 || wb.ready;
	assign adv.s2    = !vld_s2 || adv.s3;
	assign adv.s1    = !vld_s1 || adv.s2;
	assign pix.ready = adv.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv.s1) vld_s1 <= pix.valid;
			if (adv.s2) vld_s2 <= vld_s1;
			if (adv.s3) vld_s3 <= vld_s2;
		end
	end

	// stage 1: target position from source position plus placement
	logic signed [TGT_W-1:0] tx_d, ty_d;
	logic signed [TGT_W-1:0] tx_s1, ty_s1;
	logic [CHAN_W-1:0]       alpha_s1;
	logic [CHAN_W-1:0]       inv_s1;
	logic [PIX_W-1:0]        src_s1;
	logic [PIX_W-1:0]        dst_s1;

	assign tx_d = $signed({2'b00, pix.src_col}) + $signed({place_x_q[CFG_W-1], place_x_q});
	assign ty_d = $signed({2'b00, pix.src_row}) + $signed({place_y_q[CFG_W-1], place_y_q});

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			tx_s1    <= tx_d;
			ty_s1    <= ty_d;
			src_s1   <= pix.src_pixel;
			dst_s1   <= pix.dst_pixel;
			alpha_s1 <= pix.src_pixel[PIX_W-1 -: CHAN_W];
			inv_s1   <= ALPHA_OPAQUE - pix.src_pixel[PIX_W-1 -: CHAN_W];
		end
	end

	// stage 2: clip test, row offset product, alpha class
	logic              in_x, in_y;
	logic              inside_s2;
	logic [PROD_W-1:0] row_off_s2;
	logic [CFG_W-1:0]  tx_s2;
	logic              opaque_s2;
	logic              clear_s2;
	logic [PIX_W-1:0]  src_s2;

	assign in_x = !tx_s1[TGT_W-1] && (CMP_W'(tx_s1[CFG_W-1:0]) < CMP_W'(width_q));
	assign in_y = !ty_s1[TGT_W-1] && (CMP_W'(ty_s1[CFG_W-1:0]) < CMP_W'(height_q));

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			inside_s2  <= in_x && in_y;
			row_off_s2 <= ty_s1[CFG_W-1:0] * width_q;
			tx_s2      <= tx_s1[CFG_W-1:0];
			opaque_s2  <= (alpha_s1 == ALPHA_OPAQUE);
			clear_s2   <= (alpha_s1 == ALPHA_CLEAR);
			src_s2     <= src_s1;
		end
	end

	// channel blend, products registered inside at stage 2
	logic [NUM_CH*CHAN_W-1:0] blend_rgb;

	cab_blend u_blend (
		.clk        (clk),
		.adv        (adv),
		.src_rgb_s1 (src_s1[NUM_CH*CHAN_W-1:0]),
		.dst_rgb_s1 (dst_s1[NUM_CH*CHAN_W-1:0]),
		.inv_s1     (inv_s1),
		.blend_rgb  (blend_rgb)
	);

	// stage 3: output register
	logic [SUM_W-1:0]  addr_sum;
	logic [ADDR_W-1:0] addr_s3;
	logic [PIX_W-1:0]  pixel_s3;
	logic              we_s3;
	logic [PIX_W-1:0]  pixel_d;

	assign addr_sum = SUM_W'(row_off_s2) + SUM_W'(tx_s2);

	always_comb begin
		priority if (!inside_s2 || clear_s2) begin
			pixel_d = '0;
		end else if (opaque_s2) begin
			pixel_d = src_s2;
		end else begin
			// blended alpha byte is zero
			pixel_d = PIX_W'(blend_rgb);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			addr_s3  <= inside_s2 ? ADDR_W'(addr_sum) : '0;
			pixel_s3 <= pixel_d;
			we_s3    <= inside_s2 && !clear_s2;
		end
	end

	assign wb.valid        = vld_s3;
	assign wb.dest_address = addr_s3;
	assign wb.pixel_out    = pixel_s3;
	assign wb.write_enable = we_s3;

endmodule

>>> test/tb_clipped_alpha_blend_blit_top.sv
`timescale 1ns / 100ps
// self-checking bench for the clipped alpha blend blit: clipping, address and blend per pixel
// depends on cab_pkg, cab_if (cab_in_if, cab_out_if) and clipped_alpha_blend_blit_top

module tb_clipped_alpha_blend_blit_top;
	import cab_pkg::*;

	// watchdog: cycles with work outstanding but no item moving on either side
	localparam int STUCK_LIMIT = 2000;

	// one source pixel as it goes into the blit
	typedef struct {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [PIX_W-1:0]   src;
		logic [PIX_W-1:0]   dst;
	} blit_pixel_t;

	// one write-back item as it should come out
	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  pixel;
		logic              we;
	} blit_write_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wen;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	cab_in_if  pix_if ();
	cab_out_if wb_if ();

	clipped_alpha_blend_blit_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix       (pix_if),
		.wb        (wb_if)
	);

	// bench copy of the placement and clip registers, updated on every write
	logic signed [CFG_W-1:0] place_x_q;
	logic signed [CFG_W-1:0] place_y_q;
	logic [CFG_W-1:0]        width_q;
	logic [CFG_W-1:0]        height_q;

	blit_pixel_t pixel_feed[$];   // pixels still to be offered to the block
	blit_write_t due_writes[$];   // write-back items owed by the block, oldest first
	blit_pixel_t on_bus;          // pixel currently held on the input channel

	int error_count = 0;
	int stuck_cycles = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit src_gaps_on = 1'b0;
	bit snk_stalls_on = 1'b0;

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// clip bound as the block uses it: anything above the max dimension is the max
	function automatic int eff_dim(logic [CFG_W-1:0] v);
		return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(v);
	endfunction

	// what the block must write back for one pixel under the current registers
	function automatic blit_write_t blend_write(blit_pixel_t p);
		blit_write_t r;
		int w, h, tx, ty, inv, s, d, v;
		logic [CHAN_W-1:0] alpha;
		r = '{'0, '0, 1'b0};
		w = eff_dim(width_q);
		h = eff_dim(height_q);
		tx = int'(p.col) + int'(place_x_q);
		ty = int'(p.row) + int'(place_y_q);
		alpha = p.src[31:24];
		// clipped pixels come out as all zero
		if (tx >= 0 && ty >= 0 && tx < w && ty < h) begin
			r.addr = ADDR_W'(ty * w + tx);
			if (alpha == ALPHA_OPAQUE) begin
				r.pixel = p.src;
				r.we = 1'b1;
			end else if (alpha != ALPHA_CLEAR) begin
				// premultiplied over: src + dst * (255 - a) / 255, clamped, alpha byte zero
				inv = 255 - int'(alpha);
				for (int i = 0; i < NUM_CH; i++) begin
					s = int'(p.src[CHAN_W*i +: CHAN_W]);
					d = int'(p.dst[CHAN_W*i +: CHAN_W]);
					v = s + (d * inv) / 255;
					if (v > 255)
						v = 255;
					r.pixel[CHAN_W*i +: CHAN_W] = CHAN_W'(v);
				end
				r.we = 1'b1;
			end
			// clear alpha inside the window: address stays, pixel and write flag zero
		end
		return r;
	endfunction

	// idle length for either side: mostly none, some short, a few long
	function automatic int pick_idle(bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// source coordinate whose target lands mostly near the clip edges or inside,
	// with the odd fully random one
	function automatic logic [COORD_W-1:0] pick_coord(int off, int dim);
		int tgt, c;
		if ($urandom_range(0, 7) == 0)
			return COORD_W'($urandom_range(0, 2047));
		case ($urandom_range(0, 2))
			0: tgt = int'($urandom_range(0, 15)) - 8;
			1: tgt = dim - 8 + int'($urandom_range(0, 15));
			default: tgt = int'($urandom_range(0, (dim > 0) ? dim - 1 : 0));
		endcase
		c = tgt - off;
		if (c < 0 || c > 2047)
			c = $urandom_range(0, 2047);
		return COORD_W'(c);
	endfunction

	// mismatch report for one field of a write-back item
	task automatic check_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// input driver: takes the next pixel from the feed, with random gaps between items;
	// the expected write-back is worked out at the edge where the item is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (pix_if.valid && pix_if.ready)
				due_writes.push_back(blend_write(on_bus));
			if (!pix_if.valid || pix_if.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					pix_if.valid <= 1'b0;
				end else if (pixel_feed.size() != 0) begin
					on_bus = pixel_feed.pop_front();
					pix_if.valid     <= 1'b1;
					pix_if.src_col   <= on_bus.col;
					pix_if.src_row   <= on_bus.row;
					pix_if.src_pixel <= on_bus.src;
					pix_if.dst_pixel <= on_bus.dst;
					gap_left = pick_idle(src_gaps_on);
				end else begin
					pix_if.valid <= 1'b0;
				end
			end
		end
	end

	// write-back monitor: checks every taken item against the oldest one owed,
	// and drops ready at random to back-pressure the pipeline
	always @(posedge clk or negedge arst_n) begin
		blit_write_t want;
		if (!arst_n) begin
			wb_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (wb_if.valid && wb_if.ready) begin
				if (due_writes.size() == 0) begin
					$display("%0t: write-back item with none expected, addr %h pixel %h we %b",
						$time, wb_if.dest_address, wb_if.pixel_out, wb_if.write_enable);
					error_count++;
				end else begin
					want = due_writes.pop_front();
					check_field("dest_address", PIX_W'(want.addr), PIX_W'(wb_if.dest_address));
					check_field("pixel_out", want.pixel, wb_if.pixel_out);
					check_field("write_enable", PIX_W'(want.we), PIX_W'(wb_if.write_enable));
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				wb_if.ready <= 1'b0;
			end else begin
				wb_if.ready <= 1'b1;
				stall_left = pick_idle(snk_stalls_on);
			end
		end
	end

	// watchdog: only counts while something is still owed or waiting to go in
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_if.valid && pix_if.ready) || (wb_if.valid && wb_if.ready) ||
				(pixel_feed.size() == 0 && !pix_if.valid && due_writes.size() == 0)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d write-backs still owed",
					$time, stuck_cycles, due_writes.size());
				$display("tb_clipped_alpha_blend_blit_top failed");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	// single register write, only ever issued with the pipeline empty
	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_PLACE_X:     place_x_q = data;
			REG_PLACE_Y:     place_y_q = data;
			REG_DEST_WIDTH:  width_q = data;
			REG_DEST_HEIGHT: height_q = data;
		endcase
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// hold off until every pixel is in and every write-back is out, then let the
	// three pipeline stages settle
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pixel_feed.size() != 0 || pix_if.valid || due_writes.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// new placement and destination size, written between bursts only
	task automatic set_placement(int px, int py, int w, int h);
		wait_idle();
		write_reg(REG_PLACE_X, CFG_W'(px));
		write_reg(REG_PLACE_Y, CFG_W'(py));
		write_reg(REG_DEST_WIDTH, CFG_W'(w));
		write_reg(REG_DEST_HEIGHT, CFG_W'(h));
	endtask

	task automatic queue_one(int col, int row, logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst);
		blit_pixel_t p;
		p.col = COORD_W'(col);
		p.row = COORD_W'(row);
		p.src = src;
		p.dst = dst;
		pixel_feed.push_back(p);
	endtask

	// random pixels aimed at the current window; alpha leans on the clear,
	// opaque and near-limit values, colors are premultiplied half the time
	task automatic queue_pixels(int count);
		blit_pixel_t p;
		int w, h, a;
		logic [31:0] bits;
		w = eff_dim(width_q);
		h = eff_dim(height_q);
		for (int i = 0; i < count; i++) begin
			p.col = pick_coord(int'(place_x_q), w);
			p.row = pick_coord(int'(place_y_q), h);
			case ($urandom_range(0, 7))
				0: a = 0;
				1: a = 255;
				2: a = 1;
				3: a = 254;
				default: a = $urandom_range(0, 255);
			endcase
			bits = $urandom();
			if ($urandom_range(0, 1) == 0)
				p.src = {8'(a), 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
					8'($urandom_range(0, a))};
			else
				p.src = {8'(a), bits[23:0]};
			p.dst = $urandom();
			pixel_feed.push_back(p);
		end
	endtask

	initial begin
		int px, py, w, h;
		// everything known from time zero, reset held at the start
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_PLACE_X;
		cfg_data = '0;
		pix_if.valid = 1'b0;
		pix_if.src_col = '0;
		pix_if.src_row = '0;
		pix_if.src_pixel = '0;
		pix_if.dst_pixel = '0;
		wb_if.ready = 1'b0;
		place_x_q = '0;
		place_y_q = '0;
		width_q = CFG_W'(WIDTH_RST);
		height_q = CFG_W'(HEIGHT_RST);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset placement: 960 x 540 window at the origin, no idling at first
		queue_one(0, 0, 32'hFF12_3456, 32'hFFFF_FFFF);       // opaque copy, first address
		queue_one(959, 539, 32'h8040_2010, 32'hFF80_80FF);   // last pixel in the window
		queue_one(960, 0, 32'hFFFF_FFFF, 32'h0);             // just right of the window
		queue_one(0, 540, 32'hFFFF_FFFF, 32'h0);             // just below the window
		queue_one(2047, 2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // far corner, clipped
		queue_one(17, 3, 32'h00AB_CDEF, 32'h1234_5678);      // clear alpha inside
		queue_one(5, 5, 32'h01FF_FFFF, 32'hFFFF_FFFF);       // channels spill over, clamp
		queue_one(6, 5, 32'h0100_0000, 32'h00FF_FFFF);       // faintest alpha
		queue_one(7, 5, 32'hFE01_0203, 32'hFFFF_FFFF);       // alpha one short of opaque
		queue_one(8, 5, 32'h0000_0000, 32'hFFFF_FFFF);       // all zero source
		queue_one(9, 5, 32'hFFFF_FFFF, 32'h0000_0000);       // all ones source
		queue_one(10, 5, 32'h8000_0000, 32'hFFFF_FFFF);      // half alpha over white
		queue_one(11, 5, 32'h8000_0000, 32'h0000_0000);      // half alpha over black
		wait_idle();

		// extremes of placement and size, idling on both sides
		src_gaps_on = 1'b1;
		snk_stalls_on = 1'b1;
		set_placement(0, 0, 2048, 2048);
		queue_one(2047, 2047, 32'hFF00_FF00, 32'h0);         // highest address
		queue_one(0, 0, 32'h7F7F_7F7F, 32'hFFFF_FFFF);
		queue_pixels(40);
		set_placement(-2048, 2047, 1, 1);                     // whole source off to the left
		queue_one(2047, 0, 32'hFFFF_FFFF, 32'h0);
		queue_pixels(30);
		set_placement(2047, -2048, 2048, 2048);               // source off the top
		queue_one(0, 2047, 32'hFFFF_FFFF, 32'h0);
		queue_pixels(30);
		set_placement(-1, -1, 1, 1);                          // one-pixel window
		queue_one(1, 1, 32'hFFAA_5511, 32'h0);
		queue_one(0, 1, 32'hFFAA_5511, 32'h0);
		queue_one(2, 1, 32'hFFAA_5511, 32'h0);
		queue_one(1, 2, 32'hFFAA_5511, 32'h0);
		queue_pixels(30);
		set_placement(5, 3, 0, 540);                          // zero width clips all
		queue_pixels(30);
		set_placement(3, 0, 540, 0);                          // zero height clips all
		queue_pixels(30);
		set_placement(-100, -7, 4095, 3000);                  // oversized, taken as max
		queue_one(2047, 2047, 32'hFF00_0001, 32'h0);
		queue_pixels(40);
		set_placement(2047, 0, 2048, 16);                     // right-most column only
		queue_one(0, 15, 32'hC0C0_C0C0, 32'h8080_8080);
		queue_pixels(40);

		// random settings; first one without any idling, each burst split by a
		// full drain so the sender sits out until every write-back is in
		for (int ph = 0; ph < 7; ph++) begin
			src_gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
			snk_stalls_on = (ph != 0) && ($urandom_range(0, 3) != 0);
			px = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4095)) - 2048
				: int'($urandom_range(0, 80)) - 40;
			py = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4095)) - 2048
				: int'($urandom_range(0, 80)) - 40;
			case ($urandom_range(0, 5))
				0: w = $urandom_range(2049, 4095);
				1: w = $urandom_range(1, 16);
				default: w = $urandom_range(1, 2048);
			endcase
			case ($urandom_range(0, 5))
				0: h = $urandom_range(2049, 4095);
				1: h = $urandom_range(1, 16);
				default: h = $urandom_range(1, 2048);
			endcase
			set_placement(px, py, w, h);
			queue_pixels(100);
			wait_idle();
			queue_pixels(100);
		end

		wait_idle();
		repeat (8) @(negedge clk);
		if (error_count == 0)
			$display("tb_clipped_alpha_blend_blit_top passed");
		else
			$display("tb_clipped_alpha_blend_blit_top failed");
		$finish;
	end

endmodule

>>> files.f
sv/cab_pkg.sv
sv/cab_if.sv
sv/cab_blend.sv
sv/clipped_alpha_blend_blit_top.sv
test/tb_clipped_alpha_blend_blit_top.sv
